### hw/rtl/nwt_pkg.sv
package nwt_pkg;

    localparam int unsigned VALUE_W = 20;
    localparam int unsigned WORD_W  = 5;
    localparam int unsigned DIG_W   = 4;
    localparam int unsigned NUM_STG = 5;
    localparam int unsigned NUM_PH  = 9;

    localparam logic [VALUE_W-1:0] MAX_VALUE = 20'd999999;

    localparam logic [WORD_W-1:0] TOK_TEN      = 5'd10;
    localparam logic [WORD_W-1:0] TOK_TENS_OFS = 5'd18;
    localparam logic [WORD_W-1:0] TOK_HUNDRED  = 5'd28;
    localparam logic [WORD_W-1:0] TOK_THOUSAND = 5'd29;
    localparam logic [WORD_W-1:0] TOK_LAKHS    = 5'd30;

    typedef enum logic [3:0] {
        PH_LAKH_DIG = 4'd0,
        PH_LAKHS    = 4'd1,
        PH_TH_HI    = 4'd2,
        PH_TH_LO    = 4'd3,
        PH_THOUSAND = 4'd4,
        PH_HUN_DIG  = 4'd5,
        PH_HUNDRED  = 4'd6,
        PH_TENS     = 4'd7,
        PH_UNIT     = 4'd8
    } t_phase;

    typedef struct packed {
        logic [DIG_W-1:0]   digit;
        logic [VALUE_W-1:0] rem;
    } t_dig_step;

    function automatic int unsigned stage_weight(input int unsigned k);
        int unsigned w;
        case (k)
            1:       w = 100000;
            2:       w = 10000;
            3:       w = 1000;
            4:       w = 100;
            default: w = 10;
        endcase
        return w;
    endfunction

    function automatic t_dig_step dig_step(input logic [VALUE_W-1:0] rem,
                                           input int unsigned weight);
        t_dig_step r;
        r.digit = '0;
        r.rem   = rem;
        for (int unsigned m = 1; m <= 9; m++) begin
            if (rem >= VALUE_W'(m * weight)) begin
                r.digit = DIG_W'(m);
                r.rem   = rem - VALUE_W'(m * weight);
            end
        end
        return r;
    endfunction

endpackage

### hw/rtl/number_to_word_tokens_core.sv
// An accepted number passes stage 0, five digit stages and the token mask to o_strobe.
// Throughput: one token per cycle; a number gives 1 to 9 tokens on the result port,
// and numbers follow each other with no gap.
// Five digit stages stall behind the token emitter through busy; results are never held.
// Reset (i_rst_n low at a clock edge) empties all stages and drops tokens in flight.
module number_to_word_tokens_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [nwt_pkg::VALUE_W-1:0] i_value,
    output logic                        o_strobe,
    output logic [nwt_pkg::WORD_W-1:0]  o_word,
    output logic                        o_last,
    output logic                        o_out_of_range
);

    logic                        r_vld [0:nwt_pkg::NUM_STG];
    logic                        r_oor [0:nwt_pkg::NUM_STG];
    logic [nwt_pkg::VALUE_W-1:0] r_rem [0:nwt_pkg::NUM_STG];
    logic [nwt_pkg::DIG_W-1:0]   r_dig [1:nwt_pkg::NUM_STG][1:nwt_pkg::NUM_STG];
    logic                        adv   [0:nwt_pkg::NUM_STG+1];
    nwt_pkg::t_dig_step          n_step [1:nwt_pkg::NUM_STG];

    logic [nwt_pkg::NUM_PH-1:0]  r_mask;
    logic [nwt_pkg::NUM_PH-1:0]  n_mask;
    logic [nwt_pkg::NUM_PH-1:0]  load_mask;
    logic [nwt_pkg::NUM_PH-1:0]  rest_mask;
    logic                        r_em_oor;
    logic [nwt_pkg::DIG_W-1:0]   r_em_dig [1:nwt_pkg::NUM_STG];
    logic [nwt_pkg::DIG_W-1:0]   r_em_unit;
    logic                        em_load;
    nwt_pkg::t_phase             cur_ph;
    logic [nwt_pkg::WORD_W-1:0]  cur_word;

    logic                        r_strobe;
    logic [nwt_pkg::WORD_W-1:0]  r_word;
    logic                        r_last;
    logic                        r_out_oor;

    logic [nwt_pkg::DIG_W-1:0]   s_l, s_tt, s_t, s_h, s_d, s_u;
    logic [nwt_pkg::DIG_W-1:0]   e_tt, e_d;
    logic [nwt_pkg::WORD_W-1:0]  e_l, e_t, e_h, e_u;

    // stall chain: a stage moves when empty or when the next one moves
    assign rest_mask = r_mask & (r_mask - nwt_pkg::NUM_PH'(1));

    always_comb begin
        adv[nwt_pkg::NUM_STG+1] = (rest_mask == '0);
        for (int k = nwt_pkg::NUM_STG; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign busy    = !adv[0];
    assign em_load = r_vld[nwt_pkg::NUM_STG] && adv[nwt_pkg::NUM_STG+1];

    always_comb begin
        for (int k = 1; k <= nwt_pkg::NUM_STG; k++) begin
            n_step[k] = nwt_pkg::dig_step(r_rem[k-1], nwt_pkg::stage_weight(k));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= nwt_pkg::NUM_STG; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            if (adv[0]) begin
                r_vld[0] <= start;
            end
            for (int k = 1; k <= nwt_pkg::NUM_STG; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0] && start) begin
            r_rem[0] <= i_value;
            r_oor[0] <= (i_value > nwt_pkg::MAX_VALUE);
        end
        for (int k = 1; k <= nwt_pkg::NUM_STG; k++) begin
            if (adv[k]) begin
                r_rem[k]    <= n_step[k].rem;
                r_oor[k]    <= r_oor[k-1];
                r_dig[k][k] <= n_step[k].digit;
                for (int j = 1; j < k; j++) begin
                    r_dig[k][j] <= r_dig[k-1][j];
                end
            end
        end
    end

    // token plan of the number leaving the last digit stage
    always_comb begin
        s_l  = r_dig[nwt_pkg::NUM_STG][1];
        s_tt = r_dig[nwt_pkg::NUM_STG][2];
        s_t  = r_dig[nwt_pkg::NUM_STG][3];
        s_h  = r_dig[nwt_pkg::NUM_STG][4];
        s_d  = r_dig[nwt_pkg::NUM_STG][5];
        s_u  = r_rem[nwt_pkg::NUM_STG][nwt_pkg::DIG_W-1:0];
        load_mask = '0;
        if (r_oor[nwt_pkg::NUM_STG]) begin
            load_mask[nwt_pkg::PH_UNIT] = 1'b1;
        end else begin
            load_mask[nwt_pkg::PH_LAKH_DIG] = (s_l != '0);
            load_mask[nwt_pkg::PH_LAKHS]    = (s_l != '0);
            load_mask[nwt_pkg::PH_TH_HI]    = (s_tt >= 4'd2);
            load_mask[nwt_pkg::PH_TH_LO]    = (s_tt >= 4'd2) ? (s_t != '0)
                                                             : ((s_tt | s_t) != '0);
            load_mask[nwt_pkg::PH_THOUSAND] = ((s_tt | s_t) != '0);
            load_mask[nwt_pkg::PH_HUN_DIG]  = (s_h != '0);
            load_mask[nwt_pkg::PH_HUNDRED]  = (s_h != '0);
            load_mask[nwt_pkg::PH_TENS]     = (s_d >= 4'd2);
            load_mask[nwt_pkg::PH_UNIT]     = (s_d >= 4'd2) ? (s_u != '0)
                : (((s_d | s_u) != '0) ||
                   ((s_l | s_tt | s_t | s_h) == '0));
        end
    end

    assign n_mask = em_load ? load_mask : rest_mask;

    always_comb begin
        cur_ph = nwt_pkg::PH_UNIT;
        for (int p = nwt_pkg::NUM_PH - 1; p >= 0; p--) begin
            if (r_mask[p]) begin
                cur_ph = nwt_pkg::t_phase'(p[3:0]);
            end
        end
    end

    always_comb begin
        e_tt = r_em_dig[2];
        e_d  = r_em_dig[5];
        e_l  = {1'b0, r_em_dig[1]};
        e_t  = {1'b0, r_em_dig[3]};
        e_h  = {1'b0, r_em_dig[4]};
        e_u  = {1'b0, r_em_unit};
        case (cur_ph)
            nwt_pkg::PH_LAKH_DIG: cur_word = e_l;
            nwt_pkg::PH_LAKHS:    cur_word = nwt_pkg::TOK_LAKHS;
            nwt_pkg::PH_TH_HI:    cur_word = nwt_pkg::TOK_TENS_OFS + {1'b0, e_tt};
            nwt_pkg::PH_TH_LO:    cur_word = (e_tt == 4'd1) ? (nwt_pkg::TOK_TEN + e_t) : e_t;
            nwt_pkg::PH_THOUSAND: cur_word = nwt_pkg::TOK_THOUSAND;
            nwt_pkg::PH_HUN_DIG:  cur_word = e_h;
            nwt_pkg::PH_HUNDRED:  cur_word = nwt_pkg::TOK_HUNDRED;
            nwt_pkg::PH_TENS:     cur_word = nwt_pkg::TOK_TENS_OFS + {1'b0, e_d};
            nwt_pkg::PH_UNIT:     cur_word = (e_d == 4'd1) ? (nwt_pkg::TOK_TEN + e_u) : e_u;
            default:              cur_word = '0;
        endcase
        if (r_em_oor) begin
            cur_word = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_mask   <= n_mask;
            r_strobe <= (r_mask != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (em_load) begin
            r_em_oor  <= r_oor[nwt_pkg::NUM_STG];
            r_em_unit <= s_u;
            for (int j = 1; j <= nwt_pkg::NUM_STG; j++) begin
                r_em_dig[j] <= r_dig[nwt_pkg::NUM_STG][j];
            end
        end
        r_word    <= cur_word;
        r_last    <= (rest_mask == '0);
        r_out_oor <= r_em_oor;
    end

    assign o_strobe       = r_strobe;
    assign o_word         = r_word;
    assign o_last         = r_last;
    assign o_out_of_range = r_out_oor;

endmodule

### tb/sv/number_to_word_tokens_core_tb.sv
`timescale 1ns / 100ps

module number_to_word_tokens_core_tb;

    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned SETTLE_CYCLES = 24;
    localparam int unsigned RANDOM_PER_PHASE = 25;

    typedef struct {
        logic [nwt_pkg::VALUE_W-1:0] value;
        int unsigned                 gap_pct;
        bit                          wait_drain;
    } t_number_req;

    typedef struct {
        logic [nwt_pkg::WORD_W-1:0] word;
        logic                       last;
        logic                       oor;
    } t_token;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic [nwt_pkg::VALUE_W-1:0] i_value = '0;
    logic                        o_strobe;
    logic [nwt_pkg::WORD_W-1:0]  o_word;
    logic                        o_last;
    logic                        o_out_of_range;

    t_number_req                numbers_to_send[$];
    t_token                     tokens_due[$];
    logic [nwt_pkg::WORD_W-1:0] spell_buf[$];
    int unsigned                n_numbers = 0;
    int unsigned                n_accepted = 0;
    int unsigned                n_errors = 0;
    int unsigned                stall_cycles = 0;

    number_to_word_tokens_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_value        (i_value),
        .o_strobe       (o_strobe),
        .o_word         (o_word),
        .o_last         (o_last),
        .o_out_of_range (o_out_of_range)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void spell_below_100(int unsigned n);
        if (n < 20) begin
            spell_buf.push_back(nwt_pkg::WORD_W'(n));
        end else begin
            spell_buf.push_back(nwt_pkg::TOK_TENS_OFS + nwt_pkg::WORD_W'(n / 10));
            if (n % 10 != 0)
                spell_buf.push_back(nwt_pkg::WORD_W'(n % 10));
        end
    endfunction

    function automatic void spell_below_1000(int unsigned n);
        if (n < 100) begin
            spell_below_100(n);
        end else begin
            spell_buf.push_back(nwt_pkg::WORD_W'(n / 100));
            spell_buf.push_back(nwt_pkg::TOK_HUNDRED);
            if (n % 100 != 0)
                spell_below_100(n % 100);
        end
    endfunction

    function automatic void spell_below_lakh(int unsigned n);
        if (n < 1000) begin
            spell_below_1000(n);
        end else begin
            spell_below_100(n / 1000);
            spell_buf.push_back(nwt_pkg::TOK_THOUSAND);
            if (n % 1000 != 0)
                spell_below_1000(n % 1000);
        end
    endfunction

    function automatic void spell_value(logic [nwt_pkg::VALUE_W-1:0] v);
        int unsigned n;
        t_token      tok;
        n = v;
        if (v > nwt_pkg::MAX_VALUE) begin
            tok.word = '0;
            tok.last = 1'b1;
            tok.oor  = 1'b1;
            tokens_due.push_back(tok);
        end else begin
            spell_buf.delete();
            if (n < 100000) begin
                spell_below_lakh(n);
            end else begin
                spell_buf.push_back(nwt_pkg::WORD_W'(n / 100000));
                spell_buf.push_back(nwt_pkg::TOK_LAKHS);
                if (n % 100000 != 0)
                    spell_below_lakh(n % 100000);
            end
            foreach (spell_buf[k]) begin
                tok.word = spell_buf[k];
                tok.last = (k == spell_buf.size() - 1);
                tok.oor  = 1'b0;
                tokens_due.push_back(tok);
            end
        end
    endfunction

    function automatic logic [nwt_pkg::VALUE_W-1:0] random_number();
        logic [nwt_pkg::VALUE_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = nwt_pkg::VALUE_W'($urandom_range(0, 19));
            1:       v = nwt_pkg::VALUE_W'($urandom_range(20, 99));
            2:       v = nwt_pkg::VALUE_W'($urandom_range(100, 999));
            3, 4:    v = nwt_pkg::VALUE_W'($urandom_range(1000, 99999));
            5, 6, 7: v = nwt_pkg::VALUE_W'($urandom_range(100000, 999999));
            8:       v = nwt_pkg::VALUE_W'($urandom_range(10, 99) * 10000);
            default: v = nwt_pkg::VALUE_W'($urandom_range(1000000, 1048575));
        endcase
        return v;
    endfunction

    function automatic void queue_number(logic [nwt_pkg::VALUE_W-1:0] v,
                                         int unsigned gap_pct, bit wait_drain);
        t_number_req req;
        req.value      = v;
        req.gap_pct    = gap_pct;
        req.wait_drain = wait_drain;
        numbers_to_send.push_back(req);
        n_numbers++;
    endfunction

    function automatic void note_error(string msg);
        if (n_errors < 10)
            $display("ERROR @%0t: %s", $time, msg);
        n_errors++;
    endfunction

    // driver: one nonblocking write to start per edge
    always @(posedge i_clk) begin
        logic        next_start;
        t_number_req req;
        next_start = start;
        if (!i_rst_n) begin
            next_start = 1'b0;
        end else begin
            if (start && !busy) begin
                spell_value(i_value);
                n_accepted++;
                next_start = 1'b0;
            end
            if (!next_start && numbers_to_send.size() != 0) begin
                if (numbers_to_send[0].wait_drain && (tokens_due.size() != 0 || o_strobe)) begin
                    next_start = 1'b0;
                end else if ($urandom_range(0, 99) >= numbers_to_send[0].gap_pct) begin
                    req = numbers_to_send.pop_front();
                    i_value <= req.value;
                    next_start = 1'b1;
                end
            end
        end
        start <= next_start;
    end

    // monitor
    always @(posedge i_clk) begin
        t_token tok;
        if (i_rst_n && o_strobe) begin
            if (tokens_due.size() == 0) begin
                note_error($sformatf("unexpected token word=%0d last=%0b oor=%0b",
                                     o_word, o_last, o_out_of_range));
            end else begin
                tok = tokens_due.pop_front();
                if (o_word !== tok.word || o_last !== tok.last || o_out_of_range !== tok.oor)
                    note_error($sformatf({"token exp word=%0d last=%0b oor=%0b",
                                          " got word=%0d last=%0b oor=%0b"},
                                         tok.word, tok.last, tok.oor,
                                         o_word, o_last, o_out_of_range));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        logic [nwt_pkg::VALUE_W-1:0] directed[$];
        directed = '{20'd0, 20'd1, 20'd10, 20'd19, 20'd20, 20'd21, 20'd99, 20'd100,
                     20'd101, 20'd110, 20'd999, 20'd1000, 20'd1001, 20'd11000,
                     20'd20000, 20'd99999, 20'd100000, 20'd100001, 20'd120000,
                     20'd500500, 20'd512345, 20'd999000, 20'd999999, 20'd1000000,
                     20'd1048575};
        foreach (directed[k])
            queue_number(directed[k], 0, 1'b0);
        for (int unsigned k = 0; k < RANDOM_PER_PHASE; k++)
            queue_number(random_number(), 0, 1'b0);
        for (int unsigned k = 0; k < RANDOM_PER_PHASE; k++)
            queue_number(random_number(), 86, 1'b0);
        for (int unsigned k = 0; k < RANDOM_PER_PHASE; k++)
            queue_number(random_number(), 0, k == 0);
        for (int unsigned k = 0; k < RANDOM_PER_PHASE; k++)
            queue_number(random_number(), 28, k == 0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do
            @(posedge i_clk);
        while (n_accepted != n_numbers || tokens_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (tokens_due.size() != 0)
            note_error($sformatf("%0d tokens never arrived", tokens_due.size()));
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/nwt_pkg.sv
hw/rtl/number_to_word_tokens_core.sv
tb/sv/number_to_word_tokens_core_tb.sv
